@@ hw/rtl/mcsw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the multi-client stale watchdog.
package mcsw_pkg;

	localparam int MAX_CLIENTS = 16;
	localparam int IDX_W       = $clog2(MAX_CLIENTS);
	localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
	localparam int THR_W       = 16;

	localparam logic [THR_W-1:0] DEFAULT_OFF    = THR_W'(3);
	localparam logic [THR_W-1:0] DEFAULT_REBOOT = THR_W'(10);
	localparam logic [THR_W-1:0] STALE_MAX      = {THR_W{1'b1}};

	typedef enum logic [1:0] {
		OP_REGISTER     = 2'd0,
		OP_FEED         = 2'd1,
		OP_TICK         = 2'd2,
		OP_FEED_DEFAULT = 2'd3
	} op_t;

endpackage

@@ hw/rtl/multi_client_stale_watchdog_unit.sv @@
`timescale 1ns / 1ps
// Multi-client stale watchdog: client table, feed flags and the tick walker.
//
// Usage:
//   A command beat (op, handle, off_seconds, reboot_seconds) is taken on a
//   rising edge with start high and busy low. Every command yields one result
//   beat, shown for exactly one cycle with done high; the receiver cannot
//   hold it off, so it must capture the result in that cycle.
//   Register, feed and feed-default take no walk: done rises in the
//   cycle after the command, and busy stays low, so the next command may
//   follow at once.
//   Tick walks the registered clients one per cycle through a single
//   saturating incrementer and threshold compare. With N clients registered
//   busy is high while the clients are walked and done follows the last
//   client walked (earlier on a reboot hit); with no clients done rises in
//   the cycle after the command.
//   Reset empties the client table and clears busy and done; the threshold
//   and stale stores hold no reset value and are written on registration.
module multi_client_stale_watchdog_unit
	import mcsw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       op,
	input  logic [3:0]       handle,
	input  logic [THR_W-1:0] off_seconds,
	input  logic [THR_W-1:0] reboot_seconds,
	output logic             done,
	output logic [3:0]       handle_out,
	output logic             accepted,
	output logic             outputs_off,
	output logic             reboot,
	output logic [3:0]       reboot_client
);

	typedef enum logic {ST_IDLE, ST_WALK} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic             off_acc_q;
	logic             done_q;
	logic [3:0]       handle_out_q;
	logic             accepted_q;
	logic             outputs_off_q;
	logic             reboot_q;
	logic [3:0]       reboot_client_q;

	logic [THR_W-1:0] off_thr_q    [MAX_CLIENTS];
	logic [THR_W-1:0] reboot_thr_q [MAX_CLIENTS];
	logic [THR_W-1:0] stale_q      [MAX_CLIENTS];
	logic [MAX_CLIENTS-1:0] fed_q;

	logic             fire;
	op_t              op_c;
	logic             full;
	logic             feed_ok;
	logic             cur_fed;
	logic [THR_W-1:0] cur_stale;
	logic [THR_W-1:0] cur_off;
	logic [THR_W-1:0] cur_reb;
	logic [THR_W-1:0] stale_inc;
	logic             off_hit;
	logic             reb_hit;
	logic             last;

	assign fire    = start && !busy;
	assign op_c    = op_t'(op);
	assign full    = (count_q >= CNT_W'(MAX_CLIENTS));
	assign feed_ok = ({1'b0, handle} < CNT_W'(count_q)) && (CNT_W'(handle) < CNT_W'(MAX_CLIENTS));

	// shared walk unit: one client per cycle
	assign cur_fed   = fed_q[idx_q];
	assign cur_stale = stale_q[idx_q];
	assign cur_off   = off_thr_q[idx_q];
	assign cur_reb   = reboot_thr_q[idx_q];
	assign stale_inc = (cur_stale == STALE_MAX) ? cur_stale : cur_stale + THR_W'(1);
	assign off_hit   = !cur_fed && (cur_off != '0) && (stale_inc == cur_off);
	assign reb_hit   = !cur_fed && (cur_reb != '0) && (stale_inc >= cur_reb);
	assign last      = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	assign busy          = (state_q == ST_WALK);
	assign done          = done_q;
	assign handle_out    = handle_out_q;
	assign accepted      = accepted_q;
	assign outputs_off   = outputs_off_q;
	assign reboot        = reboot_q;
	assign reboot_client = reboot_client_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			count_q         <= '0;
			idx_q           <= '0;
			off_acc_q       <= 1'b0;
			done_q          <= 1'b0;
			handle_out_q    <= '0;
			accepted_q      <= 1'b0;
			outputs_off_q   <= 1'b0;
			reboot_q        <= 1'b0;
			reboot_client_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (fire) begin
						handle_out_q    <= '0;
						accepted_q      <= 1'b0;
						outputs_off_q   <= 1'b0;
						reboot_q        <= 1'b0;
						reboot_client_q <= '0;
						unique case (op_c)
							OP_REGISTER: begin
								done_q <= 1'b1;
								if (!full) begin
									count_q      <= count_q + CNT_W'(1);
									accepted_q   <= 1'b1;
									handle_out_q <= 4'(count_q);
								end
							end
							OP_FEED: begin
								done_q     <= 1'b1;
								accepted_q <= feed_ok;
							end
							OP_FEED_DEFAULT: begin
								done_q     <= 1'b1;
								accepted_q <= 1'b1;
								if (count_q == '0)
									count_q <= CNT_W'(1);
							end
							OP_TICK: begin
								if (count_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q   <= ST_WALK;
									idx_q     <= '0;
									off_acc_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (reb_hit || last) begin
						state_q         <= ST_IDLE;
						done_q          <= 1'b1;
						outputs_off_q   <= off_acc_q || off_hit;
						reboot_q        <= reb_hit;
						reboot_client_q <= reb_hit ? 4'(idx_q) : 4'd0;
					end else begin
						idx_q     <= idx_q + IDX_W'(1);
						off_acc_q <= off_acc_q || off_hit;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// client table
	always_ff @(posedge clk) begin
		if (fire) begin
			case (op_c)
				OP_REGISTER: begin
					if (!full) begin
						off_thr_q[count_q[IDX_W-1:0]]    <= off_seconds;
						reboot_thr_q[count_q[IDX_W-1:0]] <= reboot_seconds;
						stale_q[count_q[IDX_W-1:0]]      <= '0;
						fed_q[count_q[IDX_W-1:0]]        <= 1'b0;
					end
				end
				OP_FEED: begin
					if (feed_ok)
						fed_q[handle[IDX_W-1:0]] <= 1'b1;
				end
				OP_FEED_DEFAULT: begin
					if (count_q == '0) begin
						off_thr_q[0]    <= DEFAULT_OFF;
						reboot_thr_q[0] <= DEFAULT_REBOOT;
						stale_q[0]      <= '0;
					end
					fed_q[0] <= 1'b1;
				end
				default: ;
			endcase
		end else if (state_q == ST_WALK) begin
			if (cur_fed) begin
				fed_q[idx_q]   <= 1'b0;
				stale_q[idx_q] <= '0;
			end else begin
				stale_q[idx_q] <= stale_inc;
			end
		end
	end

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> count_q != '0)
		else $error("walk with an empty client table");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> CNT_W'(idx_q) < count_q)
		else $error("walk index beyond registered clients");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CLIENTS))
		else $error("client count above table size");

	a_count_only_on_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(count_q))
		else $error("client count moved without a command");

	a_flags_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(accepted) || $rose(outputs_off) || $rose(reboot)) |-> done)
		else $error("result flag without done strobe");

	a_tick_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(outputs_off || reboot) |-> !accepted && handle_out == 4'd0)
		else $error("tick result mixed with command result");

endmodule
